// ----- rtl/core/utn_pkg.sv -----
// ----------------------------------------------------------------------------
// utn_pkg
// shared widths, character codes and code point constants for the utf-8 to
// decimal character reference converter
// ----------------------------------------------------------------------------
package utn_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CODE_W  = 21;
    localparam int unsigned DIGITS  = 7;
    localparam int unsigned BCD_W   = 4 * DIGITS;
    localparam int unsigned CNT_W   = $clog2(CODE_W);
    localparam int unsigned DIG_W   = $clog2(DIGITS);

    localparam logic [CODE_W-1:0] REPLACEMENT = CODE_W'(24'h00FFFD);

    localparam logic [BYTE_W-1:0] CH_AMP  = 8'h26;
    localparam logic [BYTE_W-1:0] CH_HASH = 8'h23;
    localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] CH_SEMI = 8'h3B;

    // surrogate block 0xd800-0xdfff as bits [20:11]
    localparam logic [CODE_W-12:0] SURR_HI = 10'h01B;
    // 0xfffe/0xffff as bits [20:1]
    localparam logic [CODE_W-2:0]  NONCH_HI = 20'h07FFF;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ASCII = 4'b0010,
        S_CONV  = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    typedef enum logic [3:0] {
        PH_AMP  = 4'b0001,
        PH_HASH = 4'b0010,
        PH_DIG  = 4'b0100,
        PH_SEMI = 4'b1000
    } t_phase;

endpackage

// ----- rtl/core/utn_if.sv -----
// ----------------------------------------------------------------------------
// utn_if
// valid/ready channels: raw utf-8 bytes in, output characters out
// ----------------------------------------------------------------------------
interface utn_byte_if;
    logic                         valid;
    logic                         ready;
    logic [utn_pkg::BYTE_W-1:0]   in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface utn_char_if;
    logic                         valid;
    logic                         ready;
    logic [utn_pkg::BYTE_W-1:0]   out_char;
    logic                         last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

// ----- rtl/core/utf8_to_numeric_entity_top.sv -----
// ----------------------------------------------------------------------------
// utf8_to_numeric_entity_top
// utf-8 byte stream to characters: ascii passes through, every other code
// point becomes a decimal character reference
// ----------------------------------------------------------------------------
// One byte is taken per transfer while the block is idle. A byte that does not
// complete a code point leaves the block idle. A completed code point below
// 0x80 passes through S_ASCII, which loads it into the output register once
// that register is free. Any other code point runs 21 steps of the
// shift-and-add-3 binary to bcd loop (one shared adjust-and-shift step per
// cycle, one bit of the code point per step), then gives one output character
// per cycle while the output side does not stall: '&', '#', 3 to 7 digits and
// ';'. Invalid leads, overlong forms, surrogates, 0xfffe/0xffff and broken
// sequences all give the reference for U+FFFD; values above 0x10ffff are
// printed as they are. The last character of each run carries last_of_run. The
// output register holds the final character of a run while the next byte is taken.
// ----------------------------------------------------------------------------
module utf8_to_numeric_entity_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    utn_byte_if.sink    i_in,
    utn_char_if.source  o_out
);

    // sequencer and decoder state
    utn_pkg::t_state                  r_state,      n_state;
    utn_pkg::t_phase                  r_phase,      n_phase;
    logic [1:0]                       r_bytes_left, n_bytes_left;
    logic [1:0]                       r_seq_extra,  n_seq_extra;
    logic [utn_pkg::CODE_W-1:0]       r_acc,        n_acc;
    logic                             r_bad,        n_bad;
    logic [utn_pkg::CNT_W-1:0]        r_cnt,        n_cnt;
    logic [utn_pkg::DIG_W-1:0]        r_dig,        n_dig;
    logic                             r_out_valid,  n_out_valid;

    // payload
    logic [utn_pkg::CODE_W-1:0]       r_bin,        n_bin;
    logic [utn_pkg::BCD_W-1:0]        r_bcd,        n_bcd;
    logic [utn_pkg::BYTE_W-1:0]       r_out_char,   n_out_char;
    logic                             r_out_last,   n_out_last;

    // decode of the incoming byte
    logic                             w_in_fire;
    logic                             w_slot;
    logic [utn_pkg::BYTE_W-1:0]       w_b;
    logic [utn_pkg::CODE_W-1:0]       w_acc_shift;
    logic                             w_overlong;
    logic                             w_reject;
    logic                             w_emit;
    logic [utn_pkg::CODE_W-1:0]       w_code;

    // shared double-dabble step
    logic [utn_pkg::BCD_W-1:0]        w_bcd_adj;
    logic [utn_pkg::BCD_W-1:0]        w_bcd_step;
    logic [utn_pkg::DIG_W-1:0]        w_top_dig;

    assign i_in.ready        = (r_state == utn_pkg::S_IDLE);
    assign w_in_fire         = i_in.valid && i_in.ready;
    assign w_slot            = !r_out_valid || o_out.ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.out_char    = r_out_char;
    assign o_out.last_of_run = r_out_last;

    assign w_b         = i_in.in_byte;
    assign w_acc_shift = {r_acc[utn_pkg::CODE_W-7:0], w_b[5:0]};

    // overlong check on the finished value, by announced length
    always_comb begin
        case (r_seq_extra)
            2'd1:    w_overlong = (w_acc_shift[20:7]  == '0);
            2'd2:    w_overlong = (w_acc_shift[20:11] == '0);
            2'd3:    w_overlong = (w_acc_shift[20:16] == '0);
            default: w_overlong = 1'b1;
        endcase
    end

    assign w_reject = w_overlong
                   || (w_acc_shift[20:11] == utn_pkg::SURR_HI)
                   || (w_acc_shift[20:1]  == utn_pkg::NONCH_HI)
                   || r_bad
                   || (w_b[7:6] != 2'b10);

    // byte decoder: continuation handling or lead byte classification
    always_comb begin
        n_bytes_left = r_bytes_left;
        n_seq_extra  = r_seq_extra;
        n_acc        = r_acc;
        n_bad        = r_bad;
        w_emit       = 1'b0;
        w_code       = '0;
        if (r_bytes_left != 2'd0) begin
            n_acc        = w_acc_shift;
            n_bad        = r_bad || (w_b[7:6] != 2'b10);
            n_bytes_left = r_bytes_left - 2'd1;
            if (r_bytes_left == 2'd1) begin
                // sequence complete
                w_emit      = 1'b1;
                w_code      = w_reject ? utn_pkg::REPLACEMENT : w_acc_shift;
                n_acc       = '0;
                n_bad       = 1'b0;
                n_seq_extra = 2'd0;
            end
        end else if (!w_b[7]) begin
            w_emit = 1'b1;
            w_code = utn_pkg::CODE_W'(w_b);
        end else if (w_b[7:6] == 2'b10 || w_b[7:3] == 5'b11111) begin
            // stray continuation or no valid length
            w_emit = 1'b1;
            w_code = utn_pkg::REPLACEMENT;
        end else if (w_b[7:5] == 3'b110) begin
            n_seq_extra  = 2'd1;
            n_bytes_left = 2'd1;
            n_acc        = utn_pkg::CODE_W'(w_b[4:0]);
            n_bad        = 1'b0;
        end else if (w_b[7:4] == 4'b1110) begin
            n_seq_extra  = 2'd2;
            n_bytes_left = 2'd2;
            n_acc        = utn_pkg::CODE_W'(w_b[3:0]);
            n_bad        = 1'b0;
        end else begin
            n_seq_extra  = 2'd3;
            n_bytes_left = 2'd3;
            n_acc        = utn_pkg::CODE_W'(w_b[2:0]);
            n_bad        = 1'b0;
        end
    end

    // one shift-and-add-3 step, and the leading digit of its result
    always_comb begin
        w_top_dig = '0;
        for (int i = 0; i < utn_pkg::DIGITS; i++) begin
            if (r_bcd[i*4 +: 4] >= 4'd5) begin
                w_bcd_adj[i*4 +: 4] = r_bcd[i*4 +: 4] + 4'd3;
            end else begin
                w_bcd_adj[i*4 +: 4] = r_bcd[i*4 +: 4];
            end
        end
        w_bcd_step = {w_bcd_adj[utn_pkg::BCD_W-2:0], r_bin[utn_pkg::CODE_W-1]};
        for (int i = 0; i < utn_pkg::DIGITS; i++) begin
            if (w_bcd_step[i*4 +: 4] != 4'd0) begin
                w_top_dig = utn_pkg::DIG_W'(i);
            end
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_dig       = r_dig;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        unique case (r_state)
            utn_pkg::S_IDLE: begin
                if (w_in_fire && w_emit) begin
                    n_bin = w_code;
                    if (w_code[utn_pkg::CODE_W-1:7] == '0) begin
                        n_state = utn_pkg::S_ASCII;
                    end else begin
                        n_bcd   = '0;
                        n_cnt   = utn_pkg::CNT_W'(utn_pkg::CODE_W - 1);
                        n_state = utn_pkg::S_CONV;
                    end
                end
            end
            utn_pkg::S_ASCII: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_char  = r_bin[utn_pkg::BYTE_W-1:0];
                    n_out_last  = 1'b1;
                    n_state     = utn_pkg::S_IDLE;
                end
            end
            utn_pkg::S_CONV: begin
                n_bcd = w_bcd_step;
                n_bin = {r_bin[utn_pkg::CODE_W-2:0], 1'b0};
                n_cnt = r_cnt - utn_pkg::CNT_W'(1);
                if (r_cnt == '0) begin
                    n_dig   = w_top_dig;
                    n_phase = utn_pkg::PH_AMP;
                    n_state = utn_pkg::S_EMIT;
                end
            end
            utn_pkg::S_EMIT: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b0;
                    unique case (r_phase)
                        utn_pkg::PH_AMP: begin
                            n_out_char = utn_pkg::CH_AMP;
                            n_phase    = utn_pkg::PH_HASH;
                        end
                        utn_pkg::PH_HASH: begin
                            n_out_char = utn_pkg::CH_HASH;
                            n_phase    = utn_pkg::PH_DIG;
                        end
                        utn_pkg::PH_DIG: begin
                            n_out_char = utn_pkg::CH_ZERO
                                       + utn_pkg::BYTE_W'(r_bcd[r_dig*4 +: 4]);
                            n_dig      = r_dig - utn_pkg::DIG_W'(1);
                            if (r_dig == '0) begin
                                n_phase = utn_pkg::PH_SEMI;
                            end
                        end
                        utn_pkg::PH_SEMI: begin
                            n_out_char = utn_pkg::CH_SEMI;
                            n_out_last = 1'b1;
                            n_state    = utn_pkg::S_IDLE;
                        end
                        default: begin
                            n_phase = utn_pkg::PH_AMP;
                        end
                    endcase
                end
            end
            default: begin
                n_state = utn_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= utn_pkg::S_IDLE;
            r_phase      <= utn_pkg::PH_AMP;
            r_bytes_left <= '0;
            r_seq_extra  <= '0;
            r_acc        <= '0;
            r_bad        <= 1'b0;
            r_cnt        <= '0;
            r_dig        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_dig       <= n_dig;
            r_out_valid <= n_out_valid;
            if (w_in_fire) begin
                r_bytes_left <= n_bytes_left;
                r_seq_extra  <= n_seq_extra;
                r_acc        <= n_acc;
                r_bad        <= n_bad;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_bin      <= n_bin;
        r_bcd      <= n_bcd;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

`ifndef NO_ASSERTIONS
    // pending continuation count never exceeds what the lead announced
    a_left_le_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_left <= r_seq_extra)
        else $error("bytes_left above announced length");

    // conversion only starts once the previous run has its final char loaded
    a_conv_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == utn_pkg::S_CONV) |-> (!r_out_valid || r_out_last))
        else $error("conversion overlaps an unfinished run");

    // the bit loop ends in the emit phase
    a_conv_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == utn_pkg::S_CONV && r_cnt == '0) |=> (r_state == utn_pkg::S_EMIT))
        else $error("conversion did not hand over to emit");

    // digit pointer stays inside the bcd word while digits go out
    a_dig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == utn_pkg::S_EMIT && r_phase == utn_pkg::PH_DIG)
            |-> (r_dig < utn_pkg::DIG_W'(utn_pkg::DIGITS)))
        else $error("digit pointer out of range");
`endif

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// drives utf-8 bytes into utf8_to_numeric_entity_top and checks every output
// character and its last_of_run flag against an in-bench decoder; a short
// table of edge cases comes first, then randomised sequences, with random
// gaps on the sender, random stalls on the receiver and one long hold-off
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned BYTE_W = utn_pkg::BYTE_W;
    localparam int unsigned CODE_W = utn_pkg::CODE_W;
    localparam int unsigned DIGITS = utn_pkg::DIGITS;

    localparam logic [CODE_W-1:0] REPLACEMENT = utn_pkg::REPLACEMENT;
    localparam logic [BYTE_W-1:0] CH_AMP      = utn_pkg::CH_AMP;
    localparam logic [BYTE_W-1:0] CH_HASH     = utn_pkg::CH_HASH;
    localparam logic [BYTE_W-1:0] CH_ZERO     = utn_pkg::CH_ZERO;
    localparam logic [BYTE_W-1:0] CH_SEMI     = utn_pkg::CH_SEMI;

    localparam int LIMIT      = 400000;   // cycles before the run is declared hung
    localparam int RAND_ITEMS = 136;
    localparam int DIR_N      = 24;
    localparam int DRAIN      = 40;       // wait after the last owed character, to catch stray ones
    localparam int HOLD_LEN   = 400;      // long receiver hold-off
    localparam int HOLD_AFTER = 100;      // characters seen before the hold-off

    typedef struct {
        logic [BYTE_W-1:0] ch;
        logic              last;
    } t_char;

    typedef struct {
        logic [BYTE_W-1:0] b;
        string             text;   // empty: expectation comes from the decoder
    } t_stim;

    // ------------------------------------------------------------------------
    // clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    utn_byte_if byte_ch ();
    utn_char_if char_ch ();

    utf8_to_numeric_entity_top uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (byte_ch),
        .o_out   (char_ch)
    );

    // ------------------------------------------------------------------------
    // directed table: edge bytes, each special case, one extreme code point;
    // text is filled in only where the answer is obvious
    // ------------------------------------------------------------------------
    logic [BYTE_W-1:0] dir_byte [DIR_N] = '{
        8'h00, 8'h7F, 8'h41,                // nul passes, top of ascii, plain letter
        8'h80, 8'hBF, 8'hF8, 8'hFF,         // invalid leads
        8'hC2, 8'hA9,                       // two-byte sequence
        8'hC0, 8'h80,                       // overlong two-byte form
        8'hED, 8'hA0, 8'h80,                // surrogate
        8'hEF, 8'hBF, 8'hBF,                // noncharacter
        8'hE2, 8'h41, 8'h82,                // ascii where a continuation belongs
        8'hF7, 8'hBF, 8'hBF, 8'hBF          // largest value the decoder can form
    };
    string dir_text [DIR_N] = '{
        "", "", "A",
        "&#65533;", "&#65533;", "&#65533;", "&#65533;",
        "", "&#169;",
        "", "&#65533;",
        "", "", "&#65533;",
        "", "", "&#65533;",
        "", "", "&#65533;",
        "", "", "", "&#2097151;"
    };

    // ------------------------------------------------------------------------
    // decoder state mirrored from the block
    // ------------------------------------------------------------------------
    logic [1:0]        cont_left  = '0;   // continuation bytes still to come
    logic [1:0]        cont_total = '0;   // continuation bytes the lead announced
    logic [CODE_W-1:0] code_acc   = '0;
    logic              cont_bad   = 1'b0; // some byte in the sequence was not 10xxxxxx

    t_char pending_chars [$];   // characters the block still owes
    t_stim stim_q        [$];

    int n_taken   = 0;
    int n_out     = 0;
    int n_err     = 0;
    int cycle_cnt = 0;

    // append one owed character
    function automatic void owe_char(input logic [BYTE_W-1:0] ch, input logic last);
        t_char c;
        c.ch          = ch;
        c.last        = last;
        pending_chars = {pending_chars, c};
    endfunction

    // append one stimulus byte
    function automatic void add_stim(input logic [BYTE_W-1:0] b, input string text);
        t_stim s;
        s.b    = b;
        s.text = text;
        stim_q = {stim_q, s};
    endfunction

    // characters for one finished code point
    function automatic void queue_chars_of(input logic [CODE_W-1:0] cp);
        logic [3:0]        digit [DIGITS];
        int                nd;
        logic [CODE_W-1:0] v;
        nd = 0;
        v  = cp;
        if (v < CODE_W'('h80)) begin
            owe_char(v[BYTE_W-1:0], 1'b1);
            return;
        end
        while (v != 0) begin
            digit[nd] = 4'(v % 10);
            nd++;
            v = v / 10;
        end
        owe_char(CH_AMP, 1'b0);
        owe_char(CH_HASH, 1'b0);
        while (nd > 0) begin
            nd--;
            owe_char(CH_ZERO + BYTE_W'(digit[nd]), 1'b0);
        end
        owe_char(CH_SEMI, 1'b1);
    endfunction

    // one byte through the decoder; returns 1 when a code point is finished
    function automatic logic decode_byte(input logic [BYTE_W-1:0] b,
                                         output logic [CODE_W-1:0] cp);
        cp = '0;
        if (cont_left != 0) begin
            if (b[7:6] != 2'b10)
                cont_bad = 1'b1;
            code_acc  = {code_acc[CODE_W-7:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left != 0)
                return 1'b0;
            cp = code_acc;
            // overlong forms, surrogates, 0xfffe/0xffff and broken sequences
            if ((cont_total == 2'd1 && cp < CODE_W'('h80))
                    || (cont_total == 2'd2 && cp < CODE_W'('h800))
                    || (cont_total == 2'd3 && cp < CODE_W'('h10000))
                    || (cp >= CODE_W'('hD800) && cp <= CODE_W'('hDFFF))
                    || cp == CODE_W'('hFFFE) || cp == CODE_W'('hFFFF)
                    || cont_bad)
                cp = REPLACEMENT;
            code_acc   = '0;
            cont_bad   = 1'b0;
            cont_total = '0;
            return 1'b1;
        end
        if (b < 8'h80) begin
            cp = CODE_W'(b);
            return 1'b1;
        end
        // stray continuation byte or a lead that utf-8 never uses
        if (b < 8'hC0 || b >= 8'hF8) begin
            cp = REPLACEMENT;
            return 1'b1;
        end
        if (b < 8'hE0) begin
            cont_total = 2'd1;
            code_acc   = CODE_W'(b[4:0]);
        end else if (b < 8'hF0) begin
            cont_total = 2'd2;
            code_acc   = CODE_W'(b[3:0]);
        end else begin
            cont_total = 2'd3;
            code_acc   = CODE_W'(b[2:0]);
        end
        cont_left = cont_total;
        cont_bad  = 1'b0;
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // random stimulus: encode a code point with ncont continuation bytes;
    // broken_at picks a continuation position to replace with a non-continuation
    // ------------------------------------------------------------------------
    task automatic add_encoded(input logic [CODE_W-1:0] cp, input int ncont,
                               input int broken_at);
        logic [BYTE_W-1:0] seq [4];
        logic [BYTE_W-1:0] junk;
        case (ncont)
            0:       seq[0] = {1'b0, cp[6:0]};
            1:       seq[0] = {3'b110, cp[10:6]};
            2:       seq[0] = {4'b1110, cp[15:12]};
            default: seq[0] = {5'b11110, cp[20:18]};
        endcase
        for (int i = 1; i <= ncont; i++)
            seq[i] = {2'b10, cp[6*(ncont-i) +: 6]};
        if (broken_at >= 1 && broken_at <= ncont) begin
            junk = BYTE_W'($urandom_range(0, 255));
            while (junk[7:6] == 2'b10)
                junk = BYTE_W'($urandom_range(0, 255));
            seq[broken_at] = junk;
        end
        for (int i = 0; i <= ncont; i++)
            add_stim(seq[i], "");
    endtask

    task automatic build_random();
        int                sel;
        int                n;
        logic [CODE_W-1:0] cp;
        while (stim_q.size() < DIR_N + RAND_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 18) begin
                add_encoded(CODE_W'($urandom_range(0, 'h7F)), 0, 0);
            end else if (sel < 36) begin
                add_encoded(CODE_W'($urandom_range('h80, 'h7FF)), 1, 0);
            end else if (sel < 52) begin
                add_encoded(CODE_W'($urandom_range('h800, 'hFFFF)), 2, 0);
            end else if (sel < 58) begin
                // corners of the three-byte range
                case ($urandom_range(0, 3))
                    0:       cp = CODE_W'($urandom_range('hD800, 'hDFFF));
                    1:       cp = CODE_W'('hFFFE);
                    2:       cp = CODE_W'('hFFFF);
                    default: cp = CODE_W'('hFFFD);
                endcase
                add_encoded(cp, 2, 0);
            end else if (sel < 72) begin
                // includes values beyond the unicode range
                add_encoded(CODE_W'($urandom_range('h10000, 'h1FFFFF)), 3, 0);
            end else if (sel < 80) begin
                // overlong: value fits in fewer bytes than used
                n = $urandom_range(1, 3);
                case (n)
                    1:       cp = CODE_W'($urandom_range(0, 'h7F));
                    2:       cp = CODE_W'($urandom_range(0, 'h7FF));
                    default: cp = CODE_W'($urandom_range(0, 'hFFFF));
                endcase
                add_encoded(cp, n, 0);
            end else if (sel < 90) begin
                n  = $urandom_range(1, 3);
                cp = CODE_W'($urandom_range(0, 'h1FFFFF));
                add_encoded(cp, n, $urandom_range(1, n));
            end else begin
                // raw noise
                add_stim(BYTE_W'($urandom_range(0, 255)), "");
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // sender: walks the stimulus queue with random gaps and gap-free stretches
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        int quiet_left;
        int r;
        quiet_left      = 0;
        rst_n           <= 1'b0;
        byte_ch.valid   <= 1'b0;
        byte_ch.in_byte <= '0;

        for (int i = 0; i < DIR_N; i++)
            add_stim(dir_byte[i], dir_text[i]);
        build_random();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stim_q[i]) begin
            if (quiet_left > 0) begin
                gap = 0;
                quiet_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    quiet_left = $urandom_range(10, 30);
                    gap        = 0;
                end else if (r < 55) begin
                    gap = 0;
                end else if (r < 88) begin
                    gap = $urandom_range(1, 3);
                end else begin
                    gap = $urandom_range(6, 40);
                end
            end
            if (gap != 0) begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            byte_ch.valid   <= 1'b1;
            byte_ch.in_byte <= stim_q[i].b;
            @(posedge clk);
            while (!byte_ch.ready)
                @(posedge clk);
        end
        byte_ch.valid <= 1'b0;

        // let everything owed arrive, then watch for stray characters
        while (n_taken != stim_q.size() || pending_chars.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(posedge clk);

        if (n_err == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // receiver: random ready with long and short stalls, plus one long
    // hold-off while the sender keeps offering bytes
    // ------------------------------------------------------------------------
    initial begin
        int   run_left;
        int   hold_left;
        int   r;
        bit   held_done;
        logic ready_now;
        run_left      = 0;
        hold_left     = 0;
        held_done     = 1'b0;
        ready_now     = 1'b0;
        char_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (!held_done && n_out >= HOLD_AFTER) begin
                held_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left != 0) begin
                hold_left--;
                ready_now = 1'b0;
            end else begin
                if (run_left == 0) begin
                    r = $urandom_range(0, 99);
                    if (r < 45) begin
                        ready_now = 1'b1;
                        run_left  = $urandom_range(1, 40);
                    end else if (r < 85) begin
                        ready_now = 1'b0;
                        run_left  = $urandom_range(1, 3);
                    end else begin
                        ready_now = 1'b0;
                        run_left  = $urandom_range(8, 40);
                    end
                end
                run_left--;
            end
            char_ch.ready <= ready_now;
        end
    end

    // ------------------------------------------------------------------------
    // input side: every accepted byte goes through the decoder; table rows
    // with text queue that text instead of the decoded characters
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && byte_ch.valid && byte_ch.ready) begin : take_byte
            t_stim             it;
            logic [CODE_W-1:0] cp;
            logic              done;
            int                len;
            it  = stim_q[n_taken];
            n_taken++;
            done = decode_byte(byte_ch.in_byte, cp);
            len  = it.text.len();
            if (len != 0) begin
                for (int k = 0; k < len; k++)
                    owe_char(it.text[k], (k == len - 1));
            end else if (done) begin
                queue_chars_of(cp);
            end
        end
    end

    // ------------------------------------------------------------------------
    // output side: compare each transfer with the oldest owed character
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && char_ch.valid && char_ch.ready) begin : take_char
            t_char want;
            n_out++;
            if (pending_chars.size() == 0) begin
                n_err++;
                $display("%0t: unexpected character: expected none, got %h (last %b)",
                         $time, char_ch.out_char, char_ch.last_of_run);
            end else begin
                want = pending_chars.pop_front();
                if (char_ch.out_char !== want.ch) begin
                    n_err++;
                    $display("%0t: out_char mismatch: expected %h, got %h",
                             $time, want.ch, char_ch.out_char);
                end
                if (char_ch.last_of_run !== want.last) begin
                    n_err++;
                    $display("%0t: last_of_run mismatch: expected %b, got %b",
                             $time, want.last, char_ch.last_of_run);
                end
            end
        end
    end

    // hang guard
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("%0t: timeout with %0d characters still owed",
                     $time, pending_chars.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
